// ===== src/ecdt_pkg.sv =====
// Shared types and constants for the city distance table unit.
// Depends on nothing; every file reaches it by scoped names.
package ecdt_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEF_MAX_CITIES = 1024;
  localparam int DEF_COORD_BITS = 24;

  // Fixed field widths.
  localparam int CITY_W    = 10;
  localparam int COUNT_W   = 11;
  localparam int DIST_W    = 31;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_CITY_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INFINITE_COST = 2'd1;

  // Register reset values.
  localparam logic [COUNT_W-1:0] CITY_COUNT_RST    = 11'd1024;
  localparam logic [DIST_W-1:0]  INFINITE_COST_RST = 31'h7FFF_FFFF;

  // Operation codes carried in tuser.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Coordinates carry four fraction bits; rounding adds one half unit.
  localparam int FRAC_BITS  = 4;
  localparam int ROUND_HALF = 8;

  // Per-item control that rides along the pipeline.
  typedef struct packed {
    logic err;   // an index is at or above the city count
    logic same;  // both indexes name one city
  } meta_t;

endpackage

// ===== src/euclidean_city_distance_table_unit.sv =====
// Top level of the city distance table: coordinate store, distance pipeline,
// bit-serial square-root pipeline and result queue. Uses ecdt_pkg.
//
// Usage:
//   in_*  : input words. in_tuser is the operation (load or query); in_tdata
//           packs city_a, city_b, coord_x, coord_y from bit 0 up. A load
//           writes the X/Y coordinates of city_a and returns nothing; a query
//           returns one word on out_* with the rounded distance city_a..city_b.
//   out_* : result words. out_tdata holds the distance, out_tuser the index
//           error flag (distance then reads 0). Same-city queries return the
//           configured infinite cost.
//   cfg_* : register writes (city count, infinite cost); always ready. Write
//           only while no query is in flight.
// Throughput: one word per cycle while in_tready is high, loads and queries mixed in any order.
// Path from accept to out_tvalid: store read at the accept edge, then
//   difference, square, sum, one root bit per stage over COORD_BITS+1
//   stages, rounding into the queue, queue read register.
// The compute pipeline never stalls. A credit counter reserves a queue slot
// for each accepted query, so when the receiver holds out_tready low the
// block keeps taking words until every queue slot is reserved, then drops in_tready.
// Reset clears the credit, queue and valid state and loads the register
// defaults; the coordinate store is not cleared and needs no clearing pass.
module euclidean_city_distance_table_unit #(
  parameter int MAX_CITIES = ecdt_pkg::DEF_MAX_CITIES,
  parameter int COORD_BITS = ecdt_pkg::DEF_COORD_BITS
) (
  input  logic clk,
  input  logic rst_n,
  // input words
  input  logic in_tvalid,
  output logic in_tready,
  // {pad, coord_y, coord_x, city_b, city_a} from bit 0 up
  input  logic [((2*ecdt_pkg::CITY_W+2*COORD_BITS+7)/8)*8-1:0] in_tdata,
  // operation
  input  logic in_tuser,
  // result words
  output logic out_tvalid,
  input  logic out_tready,
  // {pad, distance} from bit 0 up
  output logic [((ecdt_pkg::DIST_W+7)/8)*8-1:0] out_tdata,
  // index_error
  output logic out_tuser,
  // configuration writes
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [ecdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ecdt_pkg::DIST_W-1:0] cfg_data
);

  localparam int C   = COORD_BITS;
  localparam int CW  = ecdt_pkg::CITY_W;
  localparam int DW  = ecdt_pkg::DIST_W;
  localparam int AW  = $clog2(MAX_CITIES);
  localparam int N   = C + 1;          // root bits
  localparam int RW  = 2 * N;          // radicand width
  localparam int OUT_DATA_W = ((DW + 7) / 8) * 8;
  localparam int FD  = 1 << $clog2(N + 8);  // queue depth
  localparam int FAW = $clog2(FD);
  localparam int CRW = $clog2(FD + 1);

  // ---------------------------------------------------------------------
  // Input field unpack
  // ---------------------------------------------------------------------
  logic          in_fire;
  logic [CW-1:0] in_city_a;
  logic [CW-1:0] in_city_b;
  logic [C-1:0]  in_coord_x;
  logic [C-1:0]  in_coord_y;

  assign in_city_a  = in_tdata[CW-1:0];
  assign in_city_b  = in_tdata[2*CW-1:CW];
  assign in_coord_x = in_tdata[2*CW+C-1:2*CW];
  assign in_coord_y = in_tdata[2*CW+2*C-1:2*CW+C];
  assign in_fire    = in_tvalid && in_tready;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [ecdt_pkg::COUNT_W-1:0] city_count_r;
  logic [DW-1:0]                infinite_cost_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_count_r    <= ecdt_pkg::CITY_COUNT_RST;
      infinite_cost_r <= ecdt_pkg::INFINITE_COST_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ecdt_pkg::CFG_CITY_COUNT:    city_count_r    <= cfg_data[ecdt_pkg::COUNT_W-1:0];
        ecdt_pkg::CFG_INFINITE_COST: infinite_cost_r <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Accept stage: index checks and coordinate store access
  // ---------------------------------------------------------------------
  logic            is_query;
  logic            load_ok;
  ecdt_pkg::meta_t meta_in;

  assign is_query = (in_tuser == ecdt_pkg::OP_QUERY);
  assign load_ok  = (32'(in_city_a) < MAX_CITIES);

  always_comb begin
    meta_in.err  = ({1'b0, in_city_a} >= city_count_r) || ({1'b0, in_city_b} >= city_count_r)
                || (32'(in_city_a) >= MAX_CITIES) || (32'(in_city_b) >= MAX_CITIES);
    meta_in.same = (in_city_a == in_city_b);
  end

  // Store entry: {y, x}. One write port, two registered read ports.
  logic [2*C-1:0] coord_mem_r [MAX_CITIES];
  logic [2*C-1:0] rd_a_r;
  logic [2*C-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (in_fire && !is_query && load_ok) begin
      coord_mem_r[AW'(in_city_a)] <= {in_coord_y, in_coord_x};
    end
    rd_a_r <= coord_mem_r[AW'(in_city_a)];
    rd_b_r <= coord_mem_r[AW'(in_city_b)];
  end

  logic            s1_vld_r;
  ecdt_pkg::meta_t s1_meta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_fire && is_query;
    end
    s1_meta_r <= meta_in;
  end

  // ---------------------------------------------------------------------
  // Stage 2: absolute coordinate differences
  // ---------------------------------------------------------------------
  logic signed [C:0] diff_x;
  logic signed [C:0] diff_y;
  logic [C-1:0]      dx_nxt;
  logic [C-1:0]      dy_nxt;

  always_comb begin
    diff_x = $signed({rd_a_r[C-1], rd_a_r[C-1:0]}) - $signed({rd_b_r[C-1], rd_b_r[C-1:0]});
    diff_y = $signed({rd_a_r[2*C-1], rd_a_r[2*C-1:C]})
           - $signed({rd_b_r[2*C-1], rd_b_r[2*C-1:C]});
    dx_nxt = diff_x[C] ? C'(-diff_x) : C'(diff_x);
    dy_nxt = diff_y[C] ? C'(-diff_y) : C'(diff_y);
  end

  logic            s2_vld_r;
  ecdt_pkg::meta_t s2_meta_r;
  logic [C-1:0]    dx_r;
  logic [C-1:0]    dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_meta_r <= s1_meta_r;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
  end

  // ---------------------------------------------------------------------
  // Stage 3: squares
  // ---------------------------------------------------------------------
  logic            s3_vld_r;
  ecdt_pkg::meta_t s3_meta_r;
  logic [2*C-1:0]  sx_r;
  logic [2*C-1:0]  sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_meta_r <= s2_meta_r;
    sx_r      <= (2*C)'(dx_r) * (2*C)'(dx_r);
    sy_r      <= (2*C)'(dy_r) * (2*C)'(dy_r);
  end

  // ---------------------------------------------------------------------
  // Square root: entry 0 holds the sum, each stage settles one root bit
  // ---------------------------------------------------------------------
  logic            sq_vld_r  [N+1];
  ecdt_pkg::meta_t sq_meta_r [N+1];
  logic [RW-1:0]   sq_rad_r  [N+1];
  logic [N+1:0]    sq_rem_r  [N+1];
  logic [N-1:0]    sq_root_r [N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else begin
      sq_vld_r[0] <= s3_vld_r;
    end
    sq_meta_r[0] <= s3_meta_r;
    sq_rad_r[0]  <= RW'(sx_r) + RW'(sy_r);
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
  end

  for (genvar k = 0; k < N; k++) begin : g_sqrt
    logic [N+1:0] rem_sh;
    logic [N+1:0] trial;
    logic         fits;

    always_comb begin
      rem_sh = {sq_rem_r[k][N-1:0], sq_rad_r[k][RW-1:RW-2]};
      trial  = {sq_root_r[k], 2'b01};
      fits   = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
      sq_meta_r[k+1] <= sq_meta_r[k];
      sq_rad_r[k+1]  <= {sq_rad_r[k][RW-3:0], 2'b00};
      sq_rem_r[k+1]  <= fits ? (rem_sh - trial) : rem_sh;
      sq_root_r[k+1] <= {sq_root_r[k][N-2:0], fits};
    end
  end

  // ---------------------------------------------------------------------
  // Rounding and result select, written into the result queue
  // ---------------------------------------------------------------------
  logic [N:0]    rnd_sum;
  logic [DW-1:0] dist_rnd;
  logic [DW-1:0] dist_sel;

  always_comb begin
    rnd_sum  = (N+1)'(sq_root_r[N]) + (N+1)'(ecdt_pkg::ROUND_HALF);
    dist_rnd = DW'(rnd_sum >> ecdt_pkg::FRAC_BITS);
    if (sq_meta_r[N].err) begin
      dist_sel = '0;
    end else if (sq_meta_r[N].same) begin
      dist_sel = infinite_cost_r;
    end else begin
      dist_sel = dist_rnd;
    end
  end

  logic [DW:0]    fifo_mem_r [FD];
  logic [FAW-1:0] wr_ptr_r;
  logic [FAW-1:0] rd_ptr_r;
  logic [FAW:0]   fifo_cnt_r;
  logic           fifo_wr;
  logic           fifo_rd;
  logic           out_vld_r;
  logic [DW-1:0]  out_dist_r;
  logic           out_err_r;
  logic           out_fire;

  assign out_fire = out_vld_r && out_tready;
  assign fifo_wr  = sq_vld_r[N];
  assign fifo_rd  = (fifo_cnt_r != '0) && (!out_vld_r || out_tready);

  always_ff @(posedge clk) begin
    if (fifo_wr) begin
      fifo_mem_r[wr_ptr_r] <= {sq_meta_r[N].err, dist_sel};
    end
    if (fifo_rd) begin
      {out_err_r, out_dist_r} <= fifo_mem_r[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (fifo_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (fifo_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fifo_cnt_r <= fifo_cnt_r + (FAW+1)'(fifo_wr) - (FAW+1)'(fifo_rd);
      if (fifo_rd) begin
        out_vld_r <= 1'b1;
      end else if (out_fire) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DATA_W'(out_dist_r);
  assign out_tuser  = out_err_r;

  // ---------------------------------------------------------------------
  // Credits: one per query from accept until its word is taken
  // ---------------------------------------------------------------------
  logic [CRW-1:0] credit_r;
  logic           credit_inc;

  assign credit_inc = in_fire && is_query;
  assign in_tready  = (credit_r < CRW'(FD));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_r + CRW'(credit_inc) - CRW'(out_fire);
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CRW'(FD))
    else $error("credit count above queue depth");

  a_queue_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (CRW+1)'(fifo_cnt_r) + (CRW+1)'(out_vld_r) <= (CRW+1)'(credit_r))
    else $error("queued results exceed outstanding queries");

  a_no_wr_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_wr |-> (fifo_cnt_r < (FAW+1)'(FD)))
    else $error("result written into a full queue");

  a_err_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_err_r |-> (out_dist_r == '0))
    else $error("index error with nonzero distance");

  a_query_takes_credit: assert property (@(posedge clk) disable iff (!rst_n)
    credit_inc && !out_fire |=> credit_r == CRW'($past(credit_r) + 1'b1))
    else $error("accepted query did not take a credit");

endmodule
